// ----- src/mips_subset_instruction_execute_macros.svh -----
// Assertion macros for the MIPS subset execute block.
// Used by the top level only; relies on signals named clock and reset.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTE_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTE_MACROS_SVH
// Same-cycle implication
`define MSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- src/mse_pkg.sv -----
// Shared types, constants and opcode codes for the MIPS subset execute block.
// No dependencies.
package mse_pkg;
   localparam int DataBytes = 65536;
   localparam int AddrW     = $clog2(DataBytes);
   localparam int RowW      = AddrW - 2;
   localparam int Rows      = DataBytes / 4;
   localparam logic [31:0] DataBase  = 32'h1000_0000;
   localparam logic [31:0] DataLimit = 32'(DataBytes - 4);
   localparam logic [31:0] DataSize  = 32'(DataBytes);

   // primary opcodes
   localparam logic [5:0] OpSpecial = 6'd0;
   localparam logic [5:0] OpJ       = 6'd2;
   localparam logic [5:0] OpJal     = 6'd3;
   localparam logic [5:0] OpBeq     = 6'd4;
   localparam logic [5:0] OpBne     = 6'd5;
   localparam logic [5:0] OpAddi    = 6'd8;
   localparam logic [5:0] OpAddiu   = 6'd9;
   localparam logic [5:0] OpSlti    = 6'd10;
   localparam logic [5:0] OpSltiu   = 6'd11;
   localparam logic [5:0] OpAndi    = 6'd12;
   localparam logic [5:0] OpOri     = 6'd13;
   localparam logic [5:0] OpXori    = 6'd14;
   localparam logic [5:0] OpLui     = 6'd15;
   localparam logic [5:0] OpLw      = 6'd35;
   localparam logic [5:0] OpSw      = 6'd43;

   // function codes of the special opcode
   localparam logic [5:0] FnSll  = 6'd0;
   localparam logic [5:0] FnSrl  = 6'd2;
   localparam logic [5:0] FnJr   = 6'd8;
   localparam logic [5:0] FnAdd  = 6'd32;
   localparam logic [5:0] FnAddu = 6'd33;
   localparam logic [5:0] FnSub  = 6'd34;
   localparam logic [5:0] FnSubu = 6'd35;
   localparam logic [5:0] FnAnd  = 6'd36;
   localparam logic [5:0] FnOr   = 6'd37;
   localparam logic [5:0] FnXor  = 6'd38;
   localparam logic [5:0] FnNor  = 6'd39;
   localparam logic [5:0] FnSlt  = 6'd42;
   localparam logic [5:0] FnSltu = 6'd43;

   // request kinds
   localparam logic ReqExecute = 1'b0;
   localparam logic ReqPreload = 1'b1;

   typedef enum logic [3:0] {
      StIdle  = 4'b0001,
      StExec  = 4'b0010,
      StLoad  = 4'b0100,
      StClear = 4'b1000
   } state_type;

   // outcome of decoding and executing one request
   typedef struct packed {
      logic [31:0] npc;
      logic        wr;
      logic [4:0]  di;
      logic [31:0] dv;
      logic        halt_set;
      logic        fault;
      logic        load;
      logic        store;
      logic        preload;
      logic [31:0] off;
   } exec_res_type;
endpackage

// ----- src/mse_req_if.sv -----
// Request channel of the MIPS subset execute block.
// Depends on nothing.
interface mse_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] instr;
   logic [15:0] preload_addr;
   logic [7:0]  preload_byte;
   modport source (output valid, opcode, instr, preload_addr, preload_byte, input ready);
   modport sink (input valid, opcode, instr, preload_addr, preload_byte, output ready);
endinterface

// ----- src/mse_rsp_if.sv -----
// Response channel of the MIPS subset execute block.
// Depends on nothing.
interface mse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        reg_written;
   logic [4:0]  dest_index;
   logic [31:0] dest_value;
   logic        halt;
   logic        addr_fault;
   modport source (output valid, next_pc, reg_written, dest_index, dest_value, halt,
                   addr_fault, input ready);
   modport sink (input valid, next_pc, reg_written, dest_index, dest_value, halt,
                 addr_fault, output ready);
endinterface

// ----- src/mips_subset_instruction_execute.sv -----
// MIPS32 integer subset execute block.
// Requests on req_ch are either one instruction word to execute or one data byte to
// preload; each request gives exactly one response on rsp_ch, in order, carrying the
// PC after the request, the register write (if any), halt and address fault.
// Path: a request is captured with its register reads, executed, and its result
// written into the output register; lw also needs a second read of the byte-lane
// data memory after the register read before it finishes.
// Throughput: one request per cycle while the response can move on, except lw,
// which holds the pipe for its data read; the register file read of the next request
// overlaps the write-back of the current one, with forwarding of the written value.
// Reset (synchronous, active high) starts a clearing pass over all Rows rows (16384 at
// 64 KiB) that fills data memory with 0xFF and zeroes the register file; no request
// is taken until it ends. A stalled response stays in the output register; the
// block keeps at most one request in execution behind it and stops taking requests
// while that one cannot retire.
// Depends on mse_pkg, mse_req_if, mse_rsp_if, mse_regfile, mse_dmem, mse_exec and
// the macro header.
`include "mips_subset_instruction_execute_macros.svh"
module mips_subset_instruction_execute (
   input  logic      clock,
   input  logic      reset,
   mse_req_if.sink   req_ch,
   mse_rsp_if.source rsp_ch
);
   mse_pkg::state_type        st_ff, st_in;
   logic [mse_pkg::RowW-1:0]  clr_ff, clr_in;
   logic [31:0]               pc_ff, pc_in;
   logic                      halted_ff, halted_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_pc_ff;
   logic                      rsp_wr_ff;
   logic [4:0]                rsp_di_ff;
   logic [31:0]               rsp_dv_ff;
   logic                      rsp_halt_ff;
   logic                      rsp_fault_ff;
   logic                      op_ff;
   logic [31:0]               instr_ff;
   logic [15:0]               pa_ff;
   logic [7:0]                pb_ff;
   logic                      fwd_a_ff, fwd_b_ff;
   logic [31:0]               fwd_data_ff;

   logic                      accept, out_free, exec_fin, load_fin, load_go, finish;
   logic                      clearing;
   logic [31:0]               qa, qb, a, b;
   logic                      rf_we;
   logic [4:0]                rf_wa;
   logic [31:0]               rf_wd;
   logic [31:0]               load_word;
   logic [3:0]                dm_we;
   logic [3:0][mse_pkg::RowW-1:0] dm_row;
   logic [3:0][7:0]           dm_wd;
   logic [7:0]                dm_q [4];
   logic [mse_pkg::RowW-1:0]  base_row;
   logic [1:0]                lo;
   mse_pkg::exec_res_type     ex;

   // handshakes
   assign clearing  = st_ff == mse_pkg::StClear;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign load_go   = st_ff == mse_pkg::StExec && ex.load;
   assign exec_fin  = st_ff == mse_pkg::StExec && !ex.load && out_free;
   assign load_fin  = st_ff == mse_pkg::StLoad && out_free;
   assign finish    = exec_fin || load_fin;
   assign req_ch.ready = !clearing && (st_ff == mse_pkg::StIdle || finish);
   assign accept    = req_ch.valid && req_ch.ready;

   // operands with zero register and forwarding from the write-back
   assign a = (instr_ff[25:21] == 5'd0) ? 32'd0 : (fwd_a_ff ? fwd_data_ff : qa);
   assign b = (instr_ff[20:16] == 5'd0) ? 32'd0 : (fwd_b_ff ? fwd_data_ff : qb);

   mse_exec u_exec (
      .opcode       (op_ff),
      .instr        (instr_ff),
      .preload_addr (pa_ff),
      .a            (a),
      .b            (b),
      .pc           (pc_ff),
      .halted       (halted_ff),
      .res          (ex)
   );

   // big-endian word from the lanes, byte i at lane lo+i
   assign lo = ex.off[1:0];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         load_word[31-8*i -: 8] = dm_q[2'(lo + 2'(i))];
      end
   end

   // register file write port
   always_comb begin
      rf_we = 1'b0;
      rf_wa = ex.di;
      rf_wd = ex.dv;
      if (clearing) begin
         rf_we = clr_ff[mse_pkg::RowW-1:5] == '0;
         rf_wa = clr_ff[4:0];
         rf_wd = 32'd0;
      end else if (exec_fin) begin
         rf_we = ex.wr;
      end else if (load_fin) begin
         rf_we = ex.di != 5'd0;
         rf_wd = load_word;
      end
   end

   mse_regfile u_regfile (
      .clock (clock),
      .rd_en (accept),
      .ra    (req_ch.instr[25:21]),
      .rb    (req_ch.instr[20:16]),
      .qa    (qa),
      .qb    (qb),
      .we    (rf_we),
      .wa    (rf_wa),
      .wd    (rf_wd)
   );

   // lane addressing: lanes below the start offset sit one row further on
   assign base_row = ex.off[mse_pkg::AddrW-1:2];
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         dm_row[l] = base_row + mse_pkg::RowW'(2'(l) < lo);
         dm_wd[l]  = b[31-8*(2'(2'(l) - lo)) -: 8];
         dm_we[l]  = 1'b0;
         if (clearing) begin
            dm_row[l] = clr_ff;
            dm_wd[l]  = 8'hFF;
            dm_we[l]  = 1'b1;
         end else if (exec_fin && ex.store) begin
            dm_we[l] = 1'b1;
         end else if (exec_fin && ex.preload) begin
            dm_row[l] = base_row;
            dm_wd[l]  = pb_ff;
            dm_we[l]  = 2'(l) == lo;
         end
      end
   end

   mse_dmem u_dmem (
      .clock (clock),
      .we    (dm_we),
      .rd_en (load_go),
      .row   (dm_row),
      .wd    (dm_wd),
      .q     (dm_q)
   );

   // sequencing
   always_comb begin
      st_in        = st_ff;
      clr_in       = clr_ff;
      pc_in        = pc_ff;
      halted_in    = halted_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      case (st_ff)
         mse_pkg::StClear: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == mse_pkg::RowW'(mse_pkg::Rows - 1)) st_in = mse_pkg::StIdle;
         end
         mse_pkg::StIdle: begin
            if (accept) st_in = mse_pkg::StExec;
         end
         mse_pkg::StExec: begin
            if (load_go) st_in = mse_pkg::StLoad;
            else if (exec_fin) st_in = accept ? mse_pkg::StExec : mse_pkg::StIdle;
         end
         mse_pkg::StLoad: begin
            if (load_fin) st_in = accept ? mse_pkg::StExec : mse_pkg::StIdle;
         end
         default: st_in = mse_pkg::StIdle;
      endcase
      if (finish) begin
         pc_in        = ex.npc;
         halted_in    = halted_ff || ex.halt_set;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= mse_pkg::StClear;
         clr_ff       <= '0;
         pc_ff        <= 32'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and forwarding flags
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_ch.opcode;
         instr_ff    <= req_ch.instr;
         pa_ff       <= req_ch.preload_addr;
         pb_ff       <= req_ch.preload_byte;
         fwd_a_ff    <= rf_we && rf_wa == req_ch.instr[25:21];
         fwd_b_ff    <= rf_we && rf_wa == req_ch.instr[20:16];
         fwd_data_ff <= rf_wd;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_pc_ff    <= ex.npc;
         rsp_wr_ff    <= rf_we;
         rsp_di_ff    <= rf_we ? ex.di : 5'd0;
         rsp_dv_ff    <= rf_we ? rf_wd : 32'd0;
         rsp_halt_ff  <= halted_ff || ex.halt_set;
         rsp_fault_ff <= ex.fault;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.next_pc     = rsp_pc_ff;
   assign rsp_ch.reg_written = rsp_wr_ff;
   assign rsp_ch.dest_index  = rsp_di_ff;
   assign rsp_ch.dest_value  = rsp_dv_ff;
   assign rsp_ch.halt        = rsp_halt_ff;
   assign rsp_ch.addr_fault  = rsp_fault_ff;

   // checks
   `MSE_ASSERT_NOW(a_no_req_in_clear, clearing, !req_ch.ready, "request taken while clearing")
   `MSE_ASSERT_NEXT(a_halt_sticks, halted_ff, halted_ff, "halt state dropped")
   `MSE_ASSERT_NOW(a_halt_no_write, halted_ff && !clearing, !rf_we && dm_we == 4'd0, "halt wr")
   `MSE_ASSERT_NEXT(a_finish_rsp, finish, rsp_valid_ff, "retired request gave no response")
endmodule

// ----- src/mse_regfile.sv -----
// General register file: 32 x 32 bits, two registered read ports, one write port.
// Depends on nothing; reads return the old value on a same-cycle write.
module mse_regfile (
   input  logic        clock,
   input  logic        rd_en,
   input  logic [4:0]  ra,
   input  logic [4:0]  rb,
   output logic [31:0] qa,
   output logic [31:0] qb,
   input  logic        we,
   input  logic [4:0]  wa,
   input  logic [31:0] wd
);
   logic [31:0] mem [32];

   // write and registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         qa <= mem[ra];
         qb <= mem[rb];
      end
   end
endmodule

// ----- src/mse_dmem.sv -----
// Data memory as four byte lanes, one row address per lane, registered read.
// Depends on mse_pkg for the memory geometry.
module mse_dmem (
   input  logic                        clock,
   input  logic [3:0]                  we,
   input  logic                        rd_en,
   input  logic [3:0][mse_pkg::RowW-1:0] row,
   input  logic [3:0][7:0]             wd,
   output logic [7:0]                  q [4]
);
   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [7:0] mem [mse_pkg::Rows];

      // single port per lane: write or registered read
      always_ff @(posedge clock) begin
         if (we[l]) begin
            mem[row[l]] <= wd[l];
         end else if (rd_en) begin
            q[l] <= mem[row[l]];
         end
      end
   end
endmodule

// ----- src/mse_exec.sv -----
// Decode and execute of one request: ALU, branch/jump target, memory address check.
// Depends on mse_pkg for codes and the result struct.
module mse_exec (
   input  logic                  opcode,
   input  logic [31:0]           instr,
   input  logic [15:0]           preload_addr,
   input  logic [31:0]           a,
   input  logic [31:0]           b,
   input  logic [31:0]           pc,
   input  logic                  halted,
   output mse_pkg::exec_res_type res
);
   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  sh;
   logic [15:0] imm;
   logic [31:0] simm;
   logic [31:0] pc4;
   logic [31:0] mem_off;
   logic        bad;

   assign op      = instr[31:26];
   assign fn      = instr[5:0];
   assign sh      = instr[10:6];
   assign imm     = instr[15:0];
   assign simm    = {{16{imm[15]}}, imm};
   assign pc4     = pc + 32'd4;
   assign mem_off = a + simm - mse_pkg::DataBase;

   always_comb begin
      res     = '0;
      bad     = 1'b0;
      res.npc = pc4;
      if (opcode == mse_pkg::ReqPreload) begin
         // byte preload: PC unchanged
         res.npc     = pc;
         res.preload = 1'b1;
         res.off     = {16'd0, preload_addr};
         res.fault   = res.off >= mse_pkg::DataSize;
         res.preload = !res.fault;
      end else if (op == mse_pkg::OpSpecial) begin
         res.di = instr[15:11];
         res.wr = 1'b1;
         case (fn)
            mse_pkg::FnSll: res.dv = b << sh;
            mse_pkg::FnSrl: res.dv = b >> sh;
            mse_pkg::FnJr: begin
               res.wr  = 1'b0;
               res.npc = a;
            end
            mse_pkg::FnAdd, mse_pkg::FnAddu: res.dv = a + b;
            mse_pkg::FnSub, mse_pkg::FnSubu: res.dv = a - b;
            mse_pkg::FnAnd:  res.dv = a & b;
            mse_pkg::FnOr:   res.dv = a | b;
            mse_pkg::FnXor:  res.dv = a ^ b;
            mse_pkg::FnNor:  res.dv = ~(a | b);
            mse_pkg::FnSlt:  res.dv = {31'd0, $signed(a) < $signed(b)};
            mse_pkg::FnSltu: res.dv = {31'd0, a < b};
            default:         bad = 1'b1;
         endcase
      end else begin
         res.di = instr[20:16];
         case (op)
            mse_pkg::OpJ: res.npc = {pc4[31:28], instr[25:0], 2'b00};
            mse_pkg::OpJal: begin
               res.npc = {pc4[31:28], instr[25:0], 2'b00};
               res.wr  = 1'b1;
               res.di  = 5'd31;
               res.dv  = pc4;
            end
            mse_pkg::OpBeq: begin
               if (a == b) res.npc = pc4 + {simm[29:0], 2'b00};
            end
            mse_pkg::OpBne: begin
               if (a != b) res.npc = pc4 + {simm[29:0], 2'b00};
            end
            mse_pkg::OpAddi, mse_pkg::OpAddiu: begin
               res.wr = 1'b1;
               res.dv = a + simm;
            end
            mse_pkg::OpSlti: begin
               res.wr = 1'b1;
               res.dv = {31'd0, $signed(a) < $signed(simm)};
            end
            mse_pkg::OpSltiu: begin
               res.wr = 1'b1;
               res.dv = {31'd0, a < simm};
            end
            mse_pkg::OpAndi: begin
               res.wr = 1'b1;
               res.dv = a & {16'd0, imm};
            end
            mse_pkg::OpOri: begin
               res.wr = 1'b1;
               res.dv = a | {16'd0, imm};
            end
            mse_pkg::OpXori: begin
               res.wr = 1'b1;
               res.dv = a ^ {16'd0, imm};
            end
            mse_pkg::OpLui: begin
               res.wr = 1'b1;
               res.dv = {imm, 16'd0};
            end
            mse_pkg::OpLw, mse_pkg::OpSw: begin
               // register write for a load happens once the data returns
               res.off   = mem_off;
               res.fault = mem_off > mse_pkg::DataLimit;
               res.load  = (op == mse_pkg::OpLw) && !res.fault;
               res.store = (op == mse_pkg::OpSw) && !res.fault;
            end
            default: bad = 1'b1;
         endcase
      end

      // unknown instruction stops the machine where it stands
      if (bad) begin
         res          = '0;
         res.npc      = pc;
         res.halt_set = 1'b1;
      end
      // stopped machine ignores everything
      if (halted) begin
         res     = '0;
         res.npc = pc;
      end
      if (res.di == 5'd0) begin
         res.wr = 1'b0;
      end
   end
endmodule
